>>> rtl/gbi_pkg.sv
`timescale 1ns / 1ps
// Package for the grid bilinear interpolator: grid geometry, datapath widths
// and the bank address helper. Depends on nothing; the top level uses it.
package gbi_pkg;

  localparam int GRID_LOG2    = 6;
  localparam int SAMPLE_WIDTH = 16;

  // Fixed field widths of the stream items.
  localparam int INDEX_W = 7;
  localparam int COORD_W = 16;

  localparam int INTERVALS = 1 << GRID_LOG2;
  localparam int FRAC_W    = COORD_W - GRID_LOG2;
  localparam int WFRAC_W   = FRAC_W + 1;          // 1 - f needs one more bit
  localparam int WEIGHT_W  = 2 * FRAC_W + 1;      // product of two weights
  localparam int ACC_W     = SAMPLE_WIDTH + 2 * FRAC_W;
  localparam int PROD_W    = SAMPLE_WIDTH + WEIGHT_W;

  // Samples are split over four banks by row and column parity.
  localparam int HALF       = (1 << (GRID_LOG2 - 1)) + 1;
  localparam int RH_W       = $clog2(HALF);
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BA_W       = $clog2(BANK_DEPTH);

  localparam int S_TDATA_RAW = 2 * INDEX_W + SAMPLE_WIDTH + 2 * COORD_W;
  localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;

  localparam sample_t SAMPLE_SIGN = sample_t'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (2 * FRAC_W - 1);

  // Request kinds carried in tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Address inside a bank: half row times bank width plus half column.
  function automatic logic [BA_W-1:0] bank_addr(input logic [RH_W-1:0] rh,
                                                input logic [RH_W-1:0] ch);
    return (BA_W'(rh) << (GRID_LOG2 - 1)) + BA_W'(rh) + BA_W'(ch);
  endfunction

endpackage

>>> rtl/grid_bilinear_interpolator.sv
`timescale 1ns / 1ps
// Top level of the grid bilinear interpolator: sample store in four parity
// banks and the blend pipeline. Depends on gbi_pkg.
//
// Usage. Items arrive on the s_axis channel. tuser selects the kind: a load
// writes one grid sample at (grid_row, grid_col) and gives no result, a query
// gives one result on the m_axis channel, the bilinear blend of the four grid
// samples around (x_pos, y_pos), rounded to nearest with halves going up.
// A load with an index beyond the grid edge is dropped.
// Throughput is one transfer per cycle of either kind while s_axis_tready is high,
// loads and queries freely mixed. The grid is held in four single-port-read banks
// chosen by the parity of row and column, so the four corners of any cell always
// come from four different banks in the same cycle.
// The pipeline has four register stages: bank read, corner weighting, pair
// sums, final sum with rounding. The first is loaded at the input transfer,
// and the result appears on m_axis from the last.
// A load takes effect at its own transfer, so a query in the very next cycle
// already sees it.
// Reset clears only the pipeline valid flags; the grid is not cleared, and a
// query must touch only samples that have been loaded.
// When the receiver stalls, the pipeline fills its empty stages first and
// s_axis_tready falls only once the stage behind the bank read is held.
module grid_bilinear_interpolator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, lowest bit up: grid_row, grid_col, sample_value, x_pos, y_pos, zero fill
  input  logic [gbi_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: req_type (0 load, 1 query)
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, lowest bit up: interp_value, zero fill
  output logic [gbi_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int IW = gbi_pkg::INDEX_W;
  localparam int SW = gbi_pkg::SAMPLE_WIDTH;
  localparam int CW = gbi_pkg::COORD_W;
  localparam int F  = gbi_pkg::FRAC_W;
  localparam int G  = gbi_pkg::GRID_LOG2;

  // Unpacked input fields.
  logic [IW-1:0]    grid_row;
  logic [IW-1:0]    grid_col;
  gbi_pkg::sample_t sample_value;
  logic [CW-1:0]    x_pos;
  logic [CW-1:0]    y_pos;

  assign grid_row     = s_axis_tdata[IW-1:0];
  assign grid_col     = s_axis_tdata[2*IW-1:IW];
  assign sample_value = s_axis_tdata[2*IW+SW-1:2*IW];
  assign x_pos        = s_axis_tdata[2*IW+SW+CW-1:2*IW+SW];
  assign y_pos        = s_axis_tdata[2*IW+SW+2*CW-1:2*IW+SW+CW];

  // Stage enables: a stage moves when it is empty or the one after it moves.
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic s_fire;

  assign en4           = !m_axis_tvalid || m_axis_tready;
  assign en3           = !v3 || en4;
  assign en2           = !v2 || en3;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Load side: bank chosen by row and column parity.
  logic                    wr_en;
  logic [1:0]              wr_bank;
  logic [gbi_pkg::BA_W-1:0] wr_addr;

  assign wr_en   = s_fire && (s_axis_tuser == gbi_pkg::REQ_LOAD) &&
                   (int'(grid_row) <= gbi_pkg::INTERVALS) &&
                   (int'(grid_col) <= gbi_pkg::INTERVALS);
  assign wr_bank = {grid_row[0], grid_col[0]};
  assign wr_addr = gbi_pkg::bank_addr(gbi_pkg::RH_W'(grid_row >> 1),
                                      gbi_pkg::RH_W'(grid_col >> 1));

  // Query side: cell index and fractional weights.
  logic [G-1:0]                  xi, yi;
  logic [F-1:0]                  fx, fy;
  logic [gbi_pkg::WFRAC_W-1:0]   gx, gy;
  logic [gbi_pkg::RH_W-1:0]      rh0, rh1, ch0, ch1;
  logic [gbi_pkg::BA_W-1:0]      rd_addr [4];

  assign xi = x_pos[CW-1 -: G];
  assign yi = y_pos[CW-1 -: G];
  assign fx = x_pos[F-1:0];
  assign fy = y_pos[F-1:0];
  assign gx = gbi_pkg::WFRAC_W'(1 << F) - gbi_pkg::WFRAC_W'(fx);
  assign gy = gbi_pkg::WFRAC_W'(1 << F) - gbi_pkg::WFRAC_W'(fy);

  // Of the rows xi and xi+1, the even one has half index (xi>>1) + xi[0],
  // the odd one xi>>1. Columns alike.
  assign rh0 = gbi_pkg::RH_W'(xi >> 1) + gbi_pkg::RH_W'(xi[0]);
  assign rh1 = gbi_pkg::RH_W'(xi >> 1);
  assign ch0 = gbi_pkg::RH_W'(yi >> 1) + gbi_pkg::RH_W'(yi[0]);
  assign ch1 = gbi_pkg::RH_W'(yi >> 1);

  assign rd_addr[0] = gbi_pkg::bank_addr(rh0, ch0);
  assign rd_addr[1] = gbi_pkg::bank_addr(rh0, ch1);
  assign rd_addr[2] = gbi_pkg::bank_addr(rh1, ch0);
  assign rd_addr[3] = gbi_pkg::bank_addr(rh1, ch1);

  // Four sample banks, one write and one registered read each.
  gbi_pkg::sample_t rd_data [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    gbi_pkg::sample_t bank_mem [gbi_pkg::BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        bank_mem[wr_addr] <= sample_value;
      end
      if (en1) begin
        rd_data[b] <= bank_mem[rd_addr[b]];
      end
    end
  end

  // Stage 1: corner weights alongside the bank read.
  logic [gbi_pkg::WEIGHT_W-1:0] w11, w12, w21, w22;
  logic                         xodd, yodd;

  always_ff @(posedge clk) begin
    if (en1) begin
      w11  <= gbi_pkg::WEIGHT_W'(gx) * gbi_pkg::WEIGHT_W'(gy);
      w12  <= gbi_pkg::WEIGHT_W'(gx) * gbi_pkg::WEIGHT_W'(fy);
      w21  <= gbi_pkg::WEIGHT_W'(fx) * gbi_pkg::WEIGHT_W'(gy);
      w22  <= gbi_pkg::WEIGHT_W'(fx) * gbi_pkg::WEIGHT_W'(fy);
      xodd <= xi[0];
      yodd <= yi[0];
    end
  end

  // Stage 2: route banks to corners, flip to offset binary, weight them.
  gbi_pkg::sample_t         f11, f12, f21, f22;
  logic [gbi_pkg::ACC_W-1:0] p11, p12, p21, p22;

  always_comb begin
    f11 = rd_data[{xodd, yodd}] ^ gbi_pkg::SAMPLE_SIGN;
    f12 = rd_data[{xodd, !yodd}] ^ gbi_pkg::SAMPLE_SIGN;
    f21 = rd_data[{!xodd, yodd}] ^ gbi_pkg::SAMPLE_SIGN;
    f22 = rd_data[{!xodd, !yodd}] ^ gbi_pkg::SAMPLE_SIGN;
  end

  // Each product stays below 2^ACC_W since its weight is at most 2^(2F).
  always_ff @(posedge clk) begin
    if (en2) begin
      p11 <= gbi_pkg::ACC_W'(gbi_pkg::PROD_W'(f11) * gbi_pkg::PROD_W'(w11));
      p12 <= gbi_pkg::ACC_W'(gbi_pkg::PROD_W'(f12) * gbi_pkg::PROD_W'(w12));
      p21 <= gbi_pkg::ACC_W'(gbi_pkg::PROD_W'(f21) * gbi_pkg::PROD_W'(w21));
      p22 <= gbi_pkg::ACC_W'(gbi_pkg::PROD_W'(f22) * gbi_pkg::PROD_W'(w22));
    end
  end

  // Stage 3: pair sums. The weights add up to 2^(2F), so nothing overflows.
  logic [gbi_pkg::ACC_W-1:0] sum_lo, sum_hi;

  always_ff @(posedge clk) begin
    if (en3) begin
      sum_lo <= p11 + p12;
      sum_hi <= p21 + p22;
    end
  end

  // Stage 4: final sum, round half up, back to two's complement.
  logic [gbi_pkg::ACC_W-1:0] acc;
  gbi_pkg::sample_t          interp_value;

  assign acc = sum_lo + sum_hi + gbi_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en4) begin
      interp_value <= acc[2*F +: SW] ^ gbi_pkg::SAMPLE_SIGN;
    end
  end

  assign m_axis_tdata = gbi_pkg::M_TDATA_W'(interp_value);

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_fire && (s_axis_tuser == gbi_pkg::REQ_QUERY);
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) m_axis_tvalid <= v3;
    end
  end

  // A load never enters the result pipeline.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_axis_tuser == gbi_pkg::REQ_LOAD) |=> !v1)
    else $error("load entered the result pipeline");

  // A query always occupies the first stage after its transfer.
  a_query_enters: assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_axis_tuser == gbi_pkg::REQ_QUERY) |=> v1)
    else $error("query lost at the input");

  // A held product stage keeps its products (p11 and p22 are checked).
  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2 && $stable(p11) && $stable(p22))
    else $error("stalled product stage changed");

  // A result only appears when the pair-sum stage held an item.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid ##1 m_axis_tvalid |-> $past(v3))
    else $error("result appeared without a query behind it");

  // The input is refused only while the bank read stage is full and held.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> v1 && v2 && v3 && m_axis_tvalid)
    else $error("input refused with a bubble in the pipeline");

endmodule
